[hw/rtl/lbs_pkg.sv]
// Package: shared constants, types and helpers for the skinning core.
package lbs_pkg;

  localparam int unsigned MaxBonesDefault  = 512;
  localparam int unsigned InfluencesDefault = 4;
  localparam int unsigned NumLanes         = 4;
  localparam int unsigned ElemsPerBone     = 12;
  localparam int unsigned ElemIdxW         = 4;
  localparam int unsigned IdW              = 10;
  localparam int unsigned WeightW          = 16;
  localparam int unsigned CoordW           = 32;
  localparam int unsigned CfgAddrW         = 2;
  localparam int unsigned IdentityWeightMax = 3;

  localparam logic [0:0] CmdWrite = 1'b0;
  localparam logic [0:0] CmdSkin  = 1'b1;

  localparam logic [CfgAddrW-1:0] RegBoneCount = 2'd0;
  localparam logic [9:0]          BoneCountReset = 10'd512;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [IdW-1:0]           bone_id_t;
  typedef logic [WeightW-1:0]       weight_t;

  // Control that travels alongside the pipeline of one lane group.
  typedef struct packed {
    logic               valid;
    logic               identity;
    logic [NumLanes-1:0] lane_en;
  } skin_ctl_t;

  function automatic coord_t sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    begin
      hi = 68'sh0_7FFF_FFFF;
      lo = -68'sh0_8000_0000;
      if (v > hi) begin
        sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
        sat32 = 32'sh8000_0000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction

endpackage

[hw/rtl/lbs_stream_if.sv]
// Interfaces: skin item input channel and result output channel.
interface lbs_in_if;
  import lbs_pkg::*;
  logic     valid;
  logic     ready;
  logic     cmd;
  coord_t   pos_x;
  coord_t   pos_y;
  coord_t   pos_z;
  bone_id_t bone_id_0;
  bone_id_t bone_id_1;
  bone_id_t bone_id_2;
  bone_id_t bone_id_3;
  weight_t  weight_0;
  weight_t  weight_1;
  weight_t  weight_2;
  weight_t  weight_3;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, bone_id_0, bone_id_1,
                  bone_id_2, bone_id_3, weight_0, weight_1, weight_2, weight_3,
                  input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, bone_id_0, bone_id_1,
                bone_id_2, bone_id_3, weight_0, weight_1, weight_2, weight_3,
                output ready);
endinterface

interface lbs_out_if;
  import lbs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   used_identity;
  modport source (output valid, out_x, out_y, out_z, used_identity, input ready);
  modport sink (input valid, out_x, out_y, out_z, used_identity, output ready);
endinterface

[hw/rtl/linear_blend_skinning_core.sv]
// Linear blend skinning core with four influence lanes and a palette in RAM.
// One item per cycle while the output register is free: writes and skin items are both accepted every such clock.
// A skin result passes the RAM read, weight multiply, element sum, position
// multiply, row sum and output registers in turn. The palette is one RAM bank
// per lane, 12 element RAMs each; all banks take each write together, one element
// per write; a slot must be written before it is used. bone_count at address 0.
module linear_blend_skinning_core #(
  parameter int unsigned MaxPaletteBones = lbs_pkg::MaxBonesDefault,
  parameter int unsigned Influences      = lbs_pkg::InfluencesDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lbs_in_if.sink                      in_ch,
  lbs_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbs_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lbs_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxPaletteBones);
  localparam int unsigned UsedLanes = (Influences < NumLanes) ? Influences : NumLanes;

  logic [9:0] bone_count_r;
  logic [AddrW:0] eff_max;
  logic adv;

  assign pready = 1'b1;
  assign prdata = (paddr == RegBoneCount) ? {22'd0, bone_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= BoneCountReset;
    end else if (psel && penable && pwrite && paddr == RegBoneCount) begin
      bone_count_r <= pwdata[9:0];
    end
  end

  always_comb begin
    if (bone_count_r == 10'd0) begin
      eff_max = '0;
    end else if (32'(bone_count_r) > MaxPaletteBones) begin
      eff_max = (AddrW+1)'(MaxPaletteBones - 1);
    end else begin
      eff_max = (AddrW+1)'(32'(bone_count_r) - 1);
    end
  end

  // Output register with stall: whole pipeline advances when output is free.
  logic out_valid_r;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;

  logic wr_en;
  logic [AddrW-1:0] wr_slot;
  assign wr_en = acc_in && in_ch.cmd == CmdWrite && 32'(in_ch.bone_id_0) < MaxPaletteBones
                 && in_ch.bone_id_1 < 10'd12;
  assign wr_slot = AddrW'(in_ch.bone_id_0);

  bone_id_t ids [NumLanes];
  weight_t  wts [NumLanes];
  assign ids = '{in_ch.bone_id_0, in_ch.bone_id_1, in_ch.bone_id_2, in_ch.bone_id_3};
  assign wts = '{in_ch.weight_0, in_ch.weight_1, in_ch.weight_2, in_ch.weight_3};

  logic [NumLanes-1:0] en;
  logic [AddrW-1:0] rslot [NumLanes];
  logic [17:0] total;
  logic signed [48:0] prod [NumLanes][ElemsPerBone];

  always_comb begin
    total = '0;
    for (int l = 0; l < NumLanes; l++) begin
      en[l] = (l < UsedLanes) && !ids[l][IdW-1];
      if (32'(ids[l]) > 32'(eff_max)) begin
        rslot[l] = eff_max[AddrW-1:0];
      end else begin
        rslot[l] = AddrW'(ids[l]);
      end
      if (en[l]) begin
        total = total + 18'(wts[l]);
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    lbs_lane #(.MaxBones(MaxPaletteBones)) u_lane (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_slot),
      .welem (in_ch.bone_id_1[ElemIdxW-1:0]),
      .wdata (in_ch.pos_x),
      .re    (adv),
      .raddr (rslot[l]),
      .adv   (adv),
      .weight(en[l] ? wts[l] : '0),
      .prod  (prod[l])
    );
  end

  // Control and position delay across the two lane stages.
  skin_ctl_t ctl0_r, ctl1_r, ctl_m;
  coord_t pos0_r [3], pos1_r [3], res [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      ctl1_r <= '0;
    end else if (adv) begin
      ctl0_r.valid    <= acc_in && in_ch.cmd == CmdSkin;
      ctl0_r.identity <= total <= 18'(IdentityWeightMax);
      ctl0_r.lane_en  <= en;
      ctl1_r <= ctl0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos0_r <= '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
      pos1_r <= pos0_r;
    end
  end

  lbs_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_in (ctl1_r),
    .prod   (prod),
    .pos_in (pos1_r),
    .ctl_out(ctl_m),
    .res    (res)
  );

  coord_t ox_r, oy_r, oz_r;
  logic   oid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_m.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r  <= res[0];
      oy_r  <= res[1];
      oz_r  <= res[2];
      oid_r <= ctl_m.identity;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;
  assign out_ch.used_identity = oid_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(ox_r))
    else $error("result changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !ctl0_r.valid)
    else $error("write produced a result");
`endif
endmodule

[hw/rtl/lbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/lbs_lane.sv]
// One influence lane: palette bank of 12 element RAMs and weighted element products.
module lbs_lane #(
  parameter int unsigned MaxBones = lbs_pkg::MaxBonesDefault
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(MaxBones)-1:0] waddr,
  input  logic [lbs_pkg::ElemIdxW-1:0] welem,
  input  lbs_pkg::coord_t             wdata,
  input  logic                        re,
  input  logic [$clog2(MaxBones)-1:0] raddr,
  input  logic                        adv,
  input  lbs_pkg::weight_t            weight,
  output logic signed [48:0]          prod [lbs_pkg::ElemsPerBone]
);
  import lbs_pkg::*;

  logic [CoordW-1:0] rdata [ElemsPerBone];
  weight_t           weight_r;
  logic signed [48:0] prod_r [ElemsPerBone];

  for (genvar e = 0; e < ElemsPerBone; e++) begin : g_elem
    lbs_ram #(.Width(CoordW), .Depth(MaxBones)) u_ram (
      .clk  (clk),
      .we   (we && (welem == ElemIdxW'(e))),
      .waddr(waddr),
      .wdata(wdata),
      .re   (re),
      .raddr(raddr),
      .rdata(rdata[e])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[e] <= $signed(rdata[e]) * $signed({1'b0, weight_r});
      end
    end
    assign prod[e] = prod_r[e];
  end

  always_ff @(posedge clk) begin
    if (re) begin
      weight_r <= weight;
    end
  end
endmodule

[hw/rtl/lbs_merge.sv]
// Merge stages: sum lane products, round matrix, transform position and saturate, or pass it for identity.
module lbs_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  lbs_pkg::skin_ctl_t     ctl_in,
  input  logic signed [48:0]     prod [lbs_pkg::NumLanes][lbs_pkg::ElemsPerBone],
  input  lbs_pkg::coord_t        pos_in [3],
  output lbs_pkg::skin_ctl_t     ctl_out,
  output lbs_pkg::coord_t        res [3]
);
  import lbs_pkg::*;

  // Stage A: element sums and rounding to Q16.16.
  skin_ctl_t          ctl_a_r;
  coord_t             m_a_r [ElemsPerBone];
  coord_t             pos_a_r [3];
  // Stage B: products of matrix and position.
  skin_ctl_t          ctl_b_r;
  logic signed [63:0] p_b_r [9];
  coord_t             t_b_r [3];
  coord_t             pos_b_r [3];
  // Stage C: final rows.
  skin_ctl_t          ctl_c_r;
  coord_t             res_c_r [3];

  logic signed [51:0] esum [ElemsPerBone];
  coord_t             m_nxt [ElemsPerBone];
  logic signed [67:0] row [3];

  always_comb begin
    for (int e = 0; e < ElemsPerBone; e++) begin
      esum[e] = 52'sd16384;
      for (int l = 0; l < NumLanes; l++) begin
        if (ctl_in.lane_en[l]) begin
          esum[e] = esum[e] + 52'(prod[l][e]);
        end
      end
      m_nxt[e] = sat32(68'(esum[e] >>> 15));
    end
  end

  // The products are Q32.32; the translation joins after rounding to Q16.16.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row[r] = 68'sd32768;
      for (int c = 0; c < 3; c++) begin
        row[r] = row[r] + 68'(p_b_r[r*3+c]);
      end
      row[r] = (row[r] >>> 16) + 68'(t_b_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else if (adv) begin
      ctl_a_r <= ctl_in;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a_r   <= m_nxt;
      pos_a_r <= pos_in;
      pos_b_r <= pos_a_r;
      for (int r = 0; r < 3; r++) begin
        t_b_r[r] <= m_a_r[r*4+3];
        for (int c = 0; c < 3; c++) begin
          p_b_r[r*3+c] <= m_a_r[r*4+c] * pos_a_r[c];
        end
      end
      for (int r = 0; r < 3; r++) begin
        res_c_r[r] <= ctl_b_r.identity ? pos_b_r[r] : sat32(row[r]);
      end
    end
  end

  assign ctl_out = ctl_c_r;
  assign res     = res_c_r;
endmodule

[tb/sv/tb_linear_blend_skinning_core.sv]
// Testbench for the skinning core: palette loads, blended vertices, scoreboard.
`timescale 1ns / 1ps

module tb_linear_blend_skinning_core;
  import lbs_pkg::*;

  typedef struct {
    logic                        cmd;
    logic [31:0]                 px, py, pz;
    logic [3:0][IdW-1:0]         id;
    logic [3:0][WeightW-1:0]     w;
  } vtx_item_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        ident;
  } skinned_t;

  localparam int NBones = MaxBonesDefault;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lbs_in_if  in_if ();
  lbs_out_if out_if ();

  linear_blend_skinning_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state, updated in acceptance order.
  logic [31:0] pal_words [NBones*ElemsPerBone];
  logic [9:0]  cur_bone_count;
  // Generator's view of which elements have been loaded.
  bit          loaded [NBones][ElemsPerBone];
  logic [9:0]  gen_bone_count;

  vtx_item_t   pending [$];
  skinned_t    expected_pos [$];
  vtx_item_t   on_bus;
  int          in_gap;
  int          out_stall;
  int          hold_left;
  logic        hold_req;
  bit          hold_used;
  bit          quiet_phase;
  int          errors;
  int          n_skins, n_writes, n_ident, n_sat;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic enqueue_item(input vtx_item_t it);
    pending = {pending, it};
  endtask

  // Apply one accepted beat: a write updates the palette model, a skin item queues the expected vertex.
  function automatic void blend_and_queue(input vtx_item_t it);
    longint acc [ElemsPerBone];
    longint mtx [ElemsPerBone];
    longint pos [3];
    longint total, hi, p, res;
    longint unsigned lo;
    int eff, slot;
    skinned_t r;
    if (it.cmd == CmdWrite) begin
      n_writes++;
      if (it.id[0] < NBones && it.id[1] < ElemsPerBone)
        pal_words[it.id[0]*ElemsPerBone + it.id[1]] = it.px;
      return;
    end
    n_skins++;
    eff = cur_bone_count;
    if (eff == 0) eff = 1;
    if (eff > NBones) eff = NBones;
    total = 0;
    for (int e = 0; e < ElemsPerBone; e++) acc[e] = 0;
    for (int s = 0; s < 4; s++) begin
      if (it.id[s][IdW-1]) continue;
      slot = it.id[s];
      if (slot > eff - 1) slot = eff - 1;
      for (int e = 0; e < ElemsPerBone; e++)
        acc[e] += longint'($signed(pal_words[slot*ElemsPerBone + e])) * longint'(it.w[s]);
      total += it.w[s];
    end
    pos[0] = longint'($signed(it.px));
    pos[1] = longint'($signed(it.py));
    pos[2] = longint'($signed(it.pz));
    if (total <= IdentityWeightMax) begin
      r.x = it.px; r.y = it.py; r.z = it.pz; r.ident = 1'b1;
      n_ident++;
    end else begin
      for (int e = 0; e < ElemsPerBone; e++) mtx[e] = clip32((acc[e] + 16384) >>> 15);
      for (int row = 0; row < 3; row++) begin
        hi = 0;
        lo = 0;
        for (int c = 0; c < 3; c++) begin
          p = mtx[row*4 + c] * pos[c];
          hi += p >>> 16;
          lo += longint'(p) & 64'hFFFF;
        end
        res = hi + longint'((lo + 32768) >> 16) + mtx[row*4 + 3];
        if (clip32(res) != res) n_sat++;
        case (row)
          0: r.x = 32'(clip32(res));
          1: r.y = 32'(clip32(res));
          default: r.z = 32'(clip32(res));
        endcase
      end
      r.ident = 1'b0;
    end
    expected_pos = {expected_pos, r};
  endfunction

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) blend_and_queue(on_bus);
      if (in_gap > 0 || pending.size() == 0) begin
        in_if.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        on_bus = pending.pop_front();
        in_if.valid     <= 1'b1;
        in_if.cmd       <= on_bus.cmd;
        in_if.pos_x     <= on_bus.px;
        in_if.pos_y     <= on_bus.py;
        in_if.pos_z     <= on_bus.pz;
        in_if.bone_id_0 <= on_bus.id[0];
        in_if.bone_id_1 <= on_bus.id[1];
        in_if.bone_id_2 <= on_bus.id[2];
        in_if.bone_id_3 <= on_bus.id[3];
        in_if.weight_0  <= on_bus.w[0];
        in_if.weight_1  <= on_bus.w[1];
        in_if.weight_2  <= on_bus.w[2];
        in_if.weight_3  <= on_bus.w[3];
        in_gap <= pick_gap();
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    skinned_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pos.size() == 0) begin
          $display("%0t: unexpected result beat x=%h y=%h z=%h id=%b", $time,
                   out_if.out_x, out_if.out_y, out_if.out_z, out_if.used_identity);
          errors++;
        end else begin
          e = expected_pos.pop_front();
          if (out_if.out_x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, out_if.out_x);
            errors++;
          end
          if (out_if.out_y !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, out_if.out_y);
            errors++;
          end
          if (out_if.out_z !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, out_if.out_z);
            errors++;
          end
          if (out_if.used_identity !== e.ident) begin
            $display("%0t: used_identity expected %b actual %b", $time, e.ident,
                     out_if.used_identity);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_stall <= pick_gap();
        out_if.ready <= (hold_left == 0) && !(hold_req && !hold_used);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CfgAddrW-1:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == RegBoneCount) cur_bone_count = d[9:0];
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_if.valid || expected_pos.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_elem(input int slot, input int el, input logic [31:0] v);
    vtx_item_t it;
    it.cmd = CmdWrite;
    it.px = v; it.py = $urandom; it.pz = $urandom;
    it.id = '0; it.w = '0;
    it.id[0] = slot; it.id[1] = el;
    it.id[2] = $urandom; it.id[3] = $urandom;
    it.w[0] = $urandom; it.w[1] = $urandom;
    if (slot < NBones && el < ElemsPerBone) loaded[slot][el] = 1'b1;
    enqueue_item(it);
  endtask

  function automatic logic [31:0] elem_value(input int el);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom;
    if (r == 2) return (r & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (el % 4 == 3) return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    if (el % 5 == 0) return 32'h0001_0000 + $urandom_range(0, 8191) - 4096;
    return $urandom_range(0, 32767) - 16384;
  endfunction

  function automatic bit slot_ready(input int s);
    for (int e = 0; e < ElemsPerBone; e++) if (!loaded[s][e]) return 0;
    return 1;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    int id, eff, s;
    eff = gen_bone_count == 0 ? 1 : (gen_bone_count > NBones ? NBones : gen_bone_count);
    for (int t = 0; t < 4; t++) begin
      case ($urandom_range(0, 9))
        0: return 10'h3FF;
        1: return 10'h200 | $urandom_range(0, 511);
        2, 3: id = $urandom_range(0, 511);
        default: id = $urandom_range(0, 31);
      endcase
      s = id > eff - 1 ? eff - 1 : id;
      if (slot_ready(s)) return id;
    end
    return 10'h3FF;
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 3);
      2: return 16'd32768;
      3: return $urandom;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic skin(input logic [3:0][IdW-1:0] ids, input logic [3:0][WeightW-1:0] ws,
                      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    vtx_item_t it;
    it.cmd = CmdSkin; it.id = ids; it.w = ws; it.px = x; it.py = y; it.pz = z;
    enqueue_item(it);
  endtask

  task automatic random_items(input int n);
    logic [3:0][IdW-1:0] ids;
    logic [3:0][WeightW-1:0] ws;
    logic [31:0] c [3];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 9) == 0)
          load_elem($urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
        else begin
          int el;
          el = $urandom_range(0, 11);
          load_elem($urandom_range(0, 31), el, elem_value(el));
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          ids[k] = pick_id();
          ws[k] = pick_weight();
        end
        for (int k = 0; k < 3; k++)
          c[k] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF) -
                 32'h0080_0000;
        skin(ids, ws, c[0], c[1], c[2]);
      end
    end
  endtask

  initial begin
    logic [9:0] settings [6];
    errors = 0; n_skins = 0; n_writes = 0; n_ident = 0; n_sat = 0; cycles = 0;
    hold_req = 1'b0; quiet_phase = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.cmd = 1'b0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    in_if.bone_id_0 = '0; in_if.bone_id_1 = '0; in_if.bone_id_2 = '0; in_if.bone_id_3 = '0;
    in_if.weight_0 = '0; in_if.weight_1 = '0; in_if.weight_2 = '0; in_if.weight_3 = '0;
    out_if.ready = 1'b0;
    cur_bone_count = BoneCountReset;
    gen_bone_count = BoneCountReset;
    for (int i = 0; i < NBones*ElemsPerBone; i++) pal_words[i] = '0;
    for (int s = 0; s < NBones; s++)
      for (int e = 0; e < ElemsPerBone; e++) loaded[s][e] = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Slot 0 is the identity, slot 1 is all extremes, slots 2, 3 and 511 are random.
    for (int e = 0; e < ElemsPerBone; e++) begin
      load_elem(0, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
      load_elem(1, e, (e % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      load_elem(2, e, elem_value(e));
      load_elem(3, e, elem_value(e));
      load_elem(NBones - 1, e, elem_value(e));
    end
    // Writes that must be ignored: slot beyond the palette, element index of twelve or more.
    load_elem(1023, 0, 32'hDEAD_BEEF);
    load_elem(600, 5, 32'h1234_5678);
    enqueue_item('{cmd: CmdWrite, px: 32'hCAFE_0000, py: 0, pz: 0,
                   id: {10'd0, 10'd0, 10'd12, 10'd2}, w: '0});
    enqueue_item('{cmd: CmdWrite, px: 32'hCAFE_0001, py: 0, pz: 0,
                   id: {10'd0, 10'd0, 10'd15, 10'd3}, w: '0});

    // Directed vertices.
    skin({4{10'h3FF}}, {4{16'd32768}}, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    skin({10'd3, 10'd2, 10'd1, 10'd0}, {16'd0, 16'd1, 16'd1, 16'd1},
         32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    skin({10'd3, 10'd2, 10'd1, 10'd0}, {16'd0, 16'd0, 16'd3, 16'd1},
         32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    skin({10'h3FF, 10'h3FF, 10'h3FF, 10'd0}, {16'd0, 16'd0, 16'd0, 16'd32768},
         32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000);
    skin({4{10'd1}}, {4{16'd32768}}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    skin({4{10'd1}}, {4{16'hFFFF}}, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    skin({10'd511, 10'd3, 10'h200, 10'd2}, {16'd8192, 16'hFFFF, 16'd32768, 16'd16384},
         32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    skin({10'd0, 10'd0, 10'd0, 10'd0}, {16'd4, 16'd0, 16'd0, 16'd0},
         32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
    drain();

    settings = '{10'd512, 10'd1, 10'd0, 10'd1023, 10'd5, 10'd512};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) begin
        gen_bone_count = $urandom_range(2, 31);
        cfg_write(RegBoneCount, gen_bone_count);
      end else begin
        gen_bone_count = settings[ph];
        cfg_write(RegBoneCount, settings[ph]);
      end
      quiet_phase = (ph == 1);
      random_items(180);
      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering beats.
        while (pending.size() > 100) @(posedge clk);
        quiet_phase = 1'b1;
        hold_req <= 1'b1;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d vertices (%0d via identity, %0d saturated rows) and %0d loads,",
             n_skins, n_ident, n_sat, n_writes);
    $display("over six bone_count settings including zero and out-of-range values.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
